// File: rtl/core/multichannel_ring_mailbox_core_defines.svh
// Assertion macros shared by the mailbox RTL.
`ifndef MULTICHANNEL_RING_MAILBOX_CORE_DEFINES_SVH
`define MULTICHANNEL_RING_MAILBOX_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mailbox assertion failed");

// Next-cycle implication, disabled during reset.
`define MRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mailbox assertion failed");

`endif

// File: rtl/core/mrm_pkg.sv
// Types, codes and constants of the multichannel ring mailbox.
`timescale 1ns / 1ps
package mrm_pkg;

  localparam int CHANNELS_DEF  = 16;
  localparam int BUF_BYTES_DEF = 256;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_CONSUME = 2'd2,
    OP_STATUS  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BAD_CH = 2'd3
  } status_t;

  localparam logic CFG_BLOCKING = 1'b0;
  localparam logic CFG_CHANNELS = 1'b1;

  typedef struct packed {
    opcode_t     opcode;
    logic [3:0]  channel;
    logic [7:0]  data_byte;
    logic        first_of_message;
    logic        last_of_message;
    logic [15:0] length;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] read_data;
    logic       notify;
    logic [7:0] available;
    logic [7:0] free_space;
    logic [7:0] contiguous;
    logic [7:0] consumed;
  } result_t;

  typedef struct packed {
    logic ptr_update;
    logic store_write;
    logic store_read;
  } act_t;

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// File: rtl/core/multichannel_ring_mailbox_core.sv
// Top level of the multichannel ring mailbox: control sequencer and memories.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall/in_word carries one command word: write a
//   byte, read a byte, consume a count or query status on one channel.
//   Output channel out_valid/out_stall/out_word returns exactly one result word
//   per command with the channel's counts after the command.
//   Configuration (cfg_en, cfg_index, cfg_data) sets blocking mode and the
//   number of enabled channels; write it only while the block is idle.
//   A result is registered from S_LOOKUP, or from S_FETCH for a byte read,
//   once the output register is free. A new command is taken only in S_IDLE,
//   after the pointer-memory lookup of the last one and, for a byte read, its
//   ring-memory access; one command in flight at a time.
//   A finished result sits in the output register; the next command is taken
//   meanwhile and waits in a holding register if the receiver still stalls.
//   Reset: all channels empty, non-blocking mode, 16 channels enabled. Pointer
//   entries carry valid bits, so no clearing pass is needed.
module multichannel_ring_mailbox_core import mrm_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  item_t      in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    out_word,
  input  logic       cfg_en,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);

`include "multichannel_ring_mailbox_core_defines.svh"

  localparam int PTR_W   = $clog2(BUF_BYTES);
  localparam int CH_W    = addr_width(CHANNELS);
  localparam int RING_AW = addr_width(CHANNELS * BUF_BYTES);
  localparam int ENT_W   = 2 * PTR_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_FETCH, S_HOLD} state_t;

  state_t                state;
  item_t                 item_q;
  result_t               res_q;
  logic                  blocking_writes;
  logic [4:0]            channels_enabled;
  logic [CHANNELS-1:0]   ptr_valid;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [CH_W-1:0]       ch_idx;
  logic [ENT_W-1:0]      ptr_rd;
  logic [ENT_W-1:0]      ptr_ent;
  logic [ENT_W-1:0]      ptr_wr;
  logic [PTR_W-1:0]      head_next;
  logic [PTR_W-1:0]      tail_next;
  logic                  drop_next;
  act_t                  act;
  result_t               res;
  result_t               fetch_res;
  logic [7:0]            ring_rd;
  logic                  lookup;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && (((state == S_LOOKUP) && !act.store_read) ||
                                 (state == S_FETCH) || (state == S_HOLD));
  assign ch_idx   = CH_W'(item_q.channel);
  assign lookup   = (state == S_LOOKUP);
  assign ptr_ent  = ptr_valid[ch_idx] ? ptr_rd : '0;
  assign ptr_wr   = {drop_next, head_next, tail_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      blocking_writes  <= 1'b0;
      channels_enabled <= 5'd16;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_BLOCKING: blocking_writes  <= cfg_data[0];
        CFG_CHANNELS: channels_enabled <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_valid <= '0;
    end else if (lookup && act.ptr_update) begin
      ptr_valid[ch_idx] <= 1'b1;
    end
  end

  mrm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CHANNELS)
  ) u_ptr_ram (
    .clk     (clk),
    .wr_en   (lookup && act.ptr_update),
    .wr_addr (ch_idx),
    .wr_data (ptr_wr),
    .rd_en   (accept),
    .rd_addr (CH_W'(in_word.channel)),
    .rd_data (ptr_rd)
  );

  mrm_calc #(
    .CHANNELS  (CHANNELS),
    .BUF_BYTES (BUF_BYTES)
  ) u_calc (
    .item             (item_q),
    .blocking_writes  (blocking_writes),
    .channels_enabled (channels_enabled),
    .head             (ptr_ent[ENT_W-2 -: PTR_W]),
    .tail             (ptr_ent[PTR_W-1:0]),
    .drop             (ptr_ent[ENT_W-1]),
    .head_next        (head_next),
    .tail_next        (tail_next),
    .drop_next        (drop_next),
    .act              (act),
    .res              (res)
  );

  mrm_ram #(
    .WIDTH (8),
    .DEPTH (CHANNELS * BUF_BYTES)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (lookup && act.store_write),
    .wr_addr (RING_AW'({item_q.channel, ptr_ent[ENT_W-2 -: PTR_W]})),
    .wr_data (item_q.data_byte),
    .rd_en   (lookup && act.store_read),
    .rd_addr (RING_AW'({item_q.channel, ptr_ent[PTR_W-1:0]})),
    .rd_data (ring_rd)
  );

  always_comb begin
    fetch_res           = res_q;
    fetch_res.read_data = ring_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_q <= in_word;
            state  <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (act.store_read) begin
            res_q <= res;
            state <= S_FETCH;
          end else if (out_free) begin
            out_word <= res;
            state    <= S_IDLE;
          end else begin
            res_q <= res;
            state <= S_HOLD;
          end
        end
        S_FETCH: begin
          if (out_free) begin
            out_word <= fetch_res;
            state    <= S_IDLE;
          end else begin
            res_q <= fetch_res;
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_word <= res_q;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MRM_ASSERT_NEXT(a_accept_lookup, clk, rst, accept, state == S_LOOKUP)
  `MRM_ASSERT_NOW(a_counts_sum, clk, rst, out_valid && out_word.status != ST_BAD_CH,
    8'(out_word.available + out_word.free_space) == 8'(BUF_BYTES - 1))
  `MRM_ASSERT_NOW(a_bad_quiet, clk, rst, out_valid && out_word.status == ST_BAD_CH,
    out_word.available == 8'd0 && out_word.notify == 1'b0 && out_word.read_data == 8'd0)
  `MRM_ASSERT_NEXT(a_lookup_leaves, clk, rst, state == S_LOOKUP, state != S_LOOKUP)

endmodule

// File: rtl/core/mrm_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mrm_ram import mrm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [addr_width(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  input  logic [addr_width(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/mrm_calc.sv
// Per-word pointer update and result computation for one channel.
`timescale 1ns / 1ps
module mrm_calc import mrm_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  item_t                            item,
  input  logic                             blocking_writes,
  input  logic [4:0]                       channels_enabled,
  input  logic [$clog2(BUF_BYTES)-1:0]     head,
  input  logic [$clog2(BUF_BYTES)-1:0]     tail,
  input  logic                             drop,
  output logic [$clog2(BUF_BYTES)-1:0]     head_next,
  output logic [$clog2(BUF_BYTES)-1:0]     tail_next,
  output logic                             drop_next,
  output act_t                             act,
  output result_t                          res
);

  localparam int PTR_W = $clog2(BUF_BYTES);

  logic             bad;
  logic [PTR_W-1:0] avail;
  logic [PTR_W-1:0] freeb;
  logic [PTR_W-1:0] cons;
  logic [PTR_W-1:0] avail_post;
  logic [PTR_W-1:0] contig;
  logic [PTR_W+7:0] avail_ext;
  logic [PTR_W+7:0] free_ext;
  logic [PTR_W+7:0] contig_ext;
  logic [PTR_W+7:0] cons_ext;
  status_t          st;
  logic             ntf;
  logic             store;

  assign bad = ({1'b0, item.channel} >= channels_enabled) ||
               ({1'b0, item.channel} >= 5'(CHANNELS));
  assign avail = head - tail;
  assign freeb = ~avail;

  always_comb begin
    head_next = head;
    tail_next = tail;
    drop_next = drop;
    st        = ST_OK;
    ntf       = 1'b0;
    store     = 1'b0;
    cons      = '0;
    act       = '0;
    unique case (item.opcode)
      OP_WRITE: begin
        if (blocking_writes) begin
          drop_next = 1'b0;
          if (freeb == '0) begin
            st  = ST_FULL;
            ntf = 1'b1;
          end else begin
            store = 1'b1;
          end
        end else if (item.first_of_message) begin
          drop_next = 1'b0;
          if (item.length > 16'(freeb)) begin
            st        = ST_FULL;
            drop_next = !item.last_of_message;
          end else begin
            store = 1'b1;
          end
        end else if (drop) begin
          st = ST_FULL;
          if (item.last_of_message) begin
            drop_next = 1'b0;
          end
        end else if (freeb == '0) begin
          st = ST_FULL;
        end else begin
          store = 1'b1;
        end
        if (store) begin
          head_next = head + PTR_W'(1);
          ntf       = item.last_of_message;
        end
      end
      OP_READ: begin
        if (avail == '0) begin
          st = ST_EMPTY;
        end else begin
          act.store_read = !bad;
          tail_next      = tail + PTR_W'(1);
        end
      end
      OP_CONSUME: begin
        cons      = (item.length < 16'(avail)) ? PTR_W'(item.length) : avail;
        tail_next = tail + cons;
      end
      OP_STATUS: begin
      end
      default: begin
      end
    endcase
    act.store_write = store && !bad;
    act.ptr_update  = !bad;
  end

  assign avail_post = head_next - tail_next;
  assign contig = (head_next > tail_next) ? (head_next - tail_next) :
                  (head_next < tail_next) ? (PTR_W'(0) - tail_next) : '0;
  assign avail_ext  = {8'd0, avail_post};
  assign free_ext   = {8'd0, ~avail_post};
  assign contig_ext = {8'd0, contig};
  assign cons_ext   = {8'd0, cons};

  always_comb begin
    res = '0;
    if (bad) begin
      res.status = ST_BAD_CH;
    end else begin
      res.status     = st;
      res.notify     = ntf;
      res.available  = avail_ext[7:0];
      res.free_space = free_ext[7:0];
      res.contiguous = contig_ext[7:0];
      res.consumed   = cons_ext[7:0];
    end
  end

endmodule

// File: bench/testbench.sv
// Self-checking testbench of the multichannel ring mailbox core.
`timescale 1ns / 1ps
module testbench;
  import mrm_pkg::*;

  typedef struct {
    logic    is_cfg;
    logic    cfg_idx;
    logic [4:0] cfg_val;
    item_t   w;
    logic    has_exp;
    result_t exp;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  item_t      in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  result_t    out_word;
  logic       cfg_en = 1'b0;
  logic       cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;

  // mailbox state as predicted
  logic [7:0] ring_data [CHANNELS_DEF][BUF_BYTES_DEF];
  logic [7:0] ring_head [CHANNELS_DEF];
  logic [7:0] ring_tail [CHANNELS_DEF];
  logic       msg_dropping [CHANNELS_DEF];
  logic       blocking_mode;
  logic [4:0] chan_limit;

  result_t    expected_results [$];
  result_t    want_result;
  step_row_t  directed [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int words_sent = 0;
  int results_checked = 0;
  int failures = 0;
  int refusals = 0;
  int empty_reads = 0;
  int bad_channel = 0;
  int notifies = 0;

  multichannel_ring_mailbox_core dut (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word, .cfg_en, .cfg_index, .cfg_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic void push_byte(logic [3:0] ch, logic [7:0] b);
    ring_data[ch][ring_head[ch]] = b;
    ring_head[ch] = ring_head[ch] + 8'd1;
  endfunction

  function automatic result_t mailbox_step(item_t w);
    result_t    r;
    logic [3:0] ch;
    logic [4:0] limit;
    logic [7:0] avail;
    logic [7:0] room;
    logic [8:0] run;
    r = '0;
    ch = w.channel;
    limit = (chan_limit < 5'd16) ? chan_limit : 5'd16;
    if ({1'b0, ch} >= limit) begin
      r.status = ST_BAD_CH;
      return r;
    end
    avail = ring_head[ch] - ring_tail[ch];
    room = 8'd255 - avail;
    r.status = ST_OK;
    case (w.opcode)
      OP_WRITE: begin
        if (blocking_mode) begin
          msg_dropping[ch] = 1'b0;
          if (room == 8'd0) begin
            r.status = ST_FULL;
            r.notify = 1'b1;
          end else begin
            push_byte(ch, w.data_byte);
            r.notify = w.last_of_message;
          end
        end else if (w.first_of_message) begin
          msg_dropping[ch] = 1'b0;
          if (w.length > {8'd0, room}) begin
            r.status = ST_FULL;
            msg_dropping[ch] = !w.last_of_message;
          end else begin
            push_byte(ch, w.data_byte);
            r.notify = w.last_of_message;
          end
        end else if (msg_dropping[ch]) begin
          r.status = ST_FULL;
          if (w.last_of_message) msg_dropping[ch] = 1'b0;
        end else if (room == 8'd0) begin
          r.status = ST_FULL;
        end else begin
          push_byte(ch, w.data_byte);
          r.notify = w.last_of_message;
        end
      end
      OP_READ: begin
        if (avail == 8'd0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_data = ring_data[ch][ring_tail[ch]];
          ring_tail[ch] = ring_tail[ch] + 8'd1;
        end
      end
      OP_CONSUME: begin
        r.consumed = (w.length < {8'd0, avail}) ? w.length[7:0] : avail;
        ring_tail[ch] = ring_tail[ch] + r.consumed;
      end
      default: ;
    endcase
    r.available = ring_head[ch] - ring_tail[ch];
    r.free_space = 8'd255 - r.available;
    if (ring_head[ch] > ring_tail[ch]) run = {1'b0, ring_head[ch] - ring_tail[ch]};
    else if (ring_head[ch] < ring_tail[ch]) run = 9'd256 - {1'b0, ring_tail[ch]};
    else run = '0;
    r.contiguous = run[7:0];
    return r;
  endfunction

  function automatic step_row_t word_row(opcode_t op, logic [3:0] ch, logic [7:0] b,
                                         logic f, logic l, logic [15:0] len);
    step_row_t r;
    r = '{is_cfg: 1'b0, cfg_idx: 1'b0, cfg_val: '0, w: '0, has_exp: 1'b0, exp: '0};
    r.w = '{opcode: op, channel: ch, data_byte: b, first_of_message: f,
            last_of_message: l, length: len};
    return r;
  endfunction

  function automatic step_row_t cfg_row(logic idx, logic [4:0] v);
    step_row_t r;
    r = '{is_cfg: 1'b1, cfg_idx: idx, cfg_val: v, w: '0, has_exp: 1'b0, exp: '0};
    return r;
  endfunction

  // typed-in result for an empty or bad channel
  function automatic step_row_t checked(step_row_t r, status_t st, logic [7:0] room);
    r.has_exp = 1'b1;
    r.exp = '0;
    r.exp.status = st;
    r.exp.free_space = room;
    return r;
  endfunction

  task automatic send_word(item_t w, logic fixed_valid, result_t fixed);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_word <= item_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = mailbox_step(w);
    expected_results.push_back(fixed_valid ? fixed : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_BLOCKING) blocking_mode = val[0];
    else chan_limit = val;
    @(negedge clk);
    cfg_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_burst(int focus_hi, int read_pct);
    int         pick;
    int         len;
    int         sel;
    logic       broken;
    logic [3:0] ch;
    logic [15:0] declared;
    item_t      w;
    pick = $urandom_range(99);
    ch = ($urandom_range(99) < 80) ? 4'($urandom_range(focus_hi)) : 4'($urandom_range(15));
    w = '{opcode: OP_STATUS, channel: ch, data_byte: 8'($urandom),
          first_of_message: 1'($urandom), last_of_message: 1'($urandom),
          length: 16'($urandom)};
    if (pick < read_pct) begin
      w.opcode = OP_READ;
      repeat ($urandom_range(1, 16)) send_word(w, 1'b0, '0);
    end else if (pick < read_pct + 5) begin
      w.opcode = OP_CONSUME;
      sel = $urandom_range(3);
      if (sel < 2) w.length = 16'($urandom_range(40));
      else if (sel == 2) w.length = 16'hFFFF;
      send_word(w, 1'b0, '0);
    end else if (pick < read_pct + 10) begin
      send_word(w, 1'b0, '0);
    end else if (pick < read_pct + 16) begin
      send_word(item_t'($urandom), 1'b0, '0);
    end else begin
      len = $urandom_range(1, 40);
      broken = ($urandom_range(9) == 0);
      sel = $urandom_range(99);
      if (sel < 70) declared = 16'(len);
      else if (sel < 85) declared = 16'($urandom);
      else declared = 16'($urandom_range(len));
      for (int i = 0; i < len; i++) begin
        w = '{opcode: OP_WRITE, channel: ch, data_byte: 8'($urandom),
              first_of_message: 1'(i == 0), last_of_message: 1'((i == len - 1) && !broken),
              length: (i == 0) ? declared : 16'($urandom)};
        send_word(w, 1'b0, '0);
      end
    end
  endtask

  task automatic random_phase(logic blocking, logic [4:0] chans, int idle_pct,
                              int stall_in, int hold, int focus_hi, int read_pct,
                              int n_words);
    int stop;
    write_reg(CFG_BLOCKING, {4'd0, blocking});
    write_reg(CFG_CHANNELS, chans);
    send_idle_pct = idle_pct;
    stall_pct = stall_in;
    hold_request = hold;
    stop = words_sent + n_words;
    while (words_sent < stop) random_burst(focus_hi, read_pct);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %p", $time, out_word);
        failures++;
      end else begin
        want_result = expected_results.pop_front();
        check_field("status", 8'(want_result.status), 8'(out_word.status));
        check_field("read_data", want_result.read_data, out_word.read_data);
        check_field("notify", 8'(want_result.notify), 8'(out_word.notify));
        check_field("available", want_result.available, out_word.available);
        check_field("free_space", want_result.free_space, out_word.free_space);
        check_field("contiguous", want_result.contiguous, out_word.contiguous);
        check_field("consumed", want_result.consumed, out_word.consumed);
        results_checked++;
        if (out_word.status == ST_FULL) refusals++;
        if (out_word.status == ST_EMPTY) empty_reads++;
        if (out_word.status == ST_BAD_CH) bad_channel++;
        if (out_word.notify) notifies++;
      end
    end
  end

  initial begin
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      ring_head[c] = '0;
      ring_tail[c] = '0;
      msg_dropping[c] = 1'b0;
    end
    blocking_mode = 1'b0;
    chan_limit = 5'd16;

    directed.push_back(checked(word_row(OP_STATUS, 4'd0, 8'h00, 1'b0, 1'b0, 16'h0000),
                               ST_OK, 8'd255));
    directed.push_back(checked(word_row(OP_READ, 4'd0, 8'hFF, 1'b1, 1'b1, 16'hFFFF),
                               ST_EMPTY, 8'd255));
    directed.push_back(checked(word_row(OP_CONSUME, 4'd15, 8'h00, 1'b0, 1'b0, 16'hFFFF),
                               ST_OK, 8'd255));
    directed.push_back(word_row(OP_WRITE, 4'd1, 8'h00, 1'b1, 1'b0, 16'd3));
    directed.push_back(word_row(OP_WRITE, 4'd1, 8'hFF, 1'b0, 1'b0, 16'd0));
    directed.push_back(word_row(OP_WRITE, 4'd1, 8'hA5, 1'b0, 1'b1, 16'd0));
    // oversized messages: single-byte refusal, then a dropped one
    directed.push_back(checked(word_row(OP_WRITE, 4'd2, 8'h11, 1'b1, 1'b1, 16'hFFFF),
                               ST_FULL, 8'd255));
    directed.push_back(checked(word_row(OP_WRITE, 4'd2, 8'h22, 1'b1, 1'b0, 16'd256),
                               ST_FULL, 8'd255));
    directed.push_back(checked(word_row(OP_WRITE, 4'd2, 8'h33, 1'b0, 1'b0, 16'd0),
                               ST_FULL, 8'd255));
    directed.push_back(checked(word_row(OP_WRITE, 4'd2, 8'h44, 1'b0, 1'b1, 16'd0),
                               ST_FULL, 8'd255));
    directed.push_back(word_row(OP_WRITE, 4'd2, 8'h5A, 1'b0, 1'b0, 16'd0));
    directed.push_back(word_row(OP_READ, 4'd1, 8'h00, 1'b0, 1'b0, 16'd0));
    directed.push_back(word_row(OP_CONSUME, 4'd1, 8'h00, 1'b0, 1'b0, 16'd1));
    directed.push_back(word_row(OP_READ, 4'd1, 8'h00, 1'b0, 1'b0, 16'd0));
    directed.push_back(word_row(OP_WRITE, 4'd2, 8'h66, 1'b1, 1'b1, 16'd254));
    directed.push_back(cfg_row(CFG_BLOCKING, 5'd1));
    directed.push_back(word_row(OP_WRITE, 4'd3, 8'h77, 1'b0, 1'b1, 16'd0));
    directed.push_back(word_row(OP_WRITE, 4'd3, 8'h88, 1'b1, 1'b0, 16'hFFFF));
    directed.push_back(cfg_row(CFG_BLOCKING, 5'd0));
    directed.push_back(cfg_row(CFG_CHANNELS, 5'd0));
    directed.push_back(checked(word_row(OP_STATUS, 4'd0, 8'h00, 1'b0, 1'b0, 16'd0),
                               ST_BAD_CH, 8'd0));
    directed.push_back(checked(word_row(OP_WRITE, 4'd15, 8'hFF, 1'b1, 1'b1, 16'd1),
                               ST_BAD_CH, 8'd0));
    directed.push_back(cfg_row(CFG_CHANNELS, 5'd31));
    directed.push_back(word_row(OP_STATUS, 4'd15, 8'h00, 1'b0, 1'b0, 16'd0));
    directed.push_back(cfg_row(CFG_CHANNELS, 5'd1));
    directed.push_back(checked(word_row(OP_READ, 4'd1, 8'h00, 1'b0, 1'b0, 16'd0),
                               ST_BAD_CH, 8'd0));
    directed.push_back(checked(word_row(OP_READ, 4'd0, 8'h00, 1'b0, 1'b0, 16'd0),
                               ST_EMPTY, 8'd255));
    directed.push_back(cfg_row(CFG_CHANNELS, 5'd16));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[k]) begin
      if (directed[k].is_cfg) write_reg(directed[k].cfg_idx, directed[k].cfg_val);
      else send_word(directed[k].w, directed[k].has_exp, directed[k].exp);
    end

    random_phase(1'b0, 5'd16, 0, 0, 0, 3, 30, 150);
    random_phase(1'b0, 5'd16, 71, 0, 0, 3, 35, 150);
    random_phase(1'b1, 5'd1, 0, 71, 80, 0, 2, 300);
    random_phase(1'b0, 5'd31, 10, 10, 0, 1, 45, 50);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("summary: %0d commands, %0d results checked; %0d refused, %0d empty reads,",
             words_sent, results_checked, refusals, empty_reads);
    $display("summary: %0d bad-channel, %0d notify; both write modes, 0/1/16/31 channels",
             bad_channel, notifies);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
